// File: sv/tcv_pkg.sv
// Package with shared constants and types for the triangle cull and viewport block.
package tcv_pkg;

  localparam int FracBitsDefault = 16;
  localparam int CoordW = 32;
  localparam int SizeW = 13;
  localparam int NumDiv = 9;
  // Bits of quotient produced per restoring-division stage.
  localparam int DivStep = 4;

  typedef enum logic [1:0] {
    CFG_BACK_CULL = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic         back_cull_enable;
    logic [SizeW-1:0] screen_width;
    logic [SizeW-1:0] screen_height;
  } cfg_t;

endpackage

// File: sv/tcv_div.sv
// Pipelined signed divider with zero-divisor and saturation handling.
module tcv_div #(
  parameter int FRAC_BITS = tcv_pkg::FracBitsDefault
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic signed [tcv_pkg::CoordW-1:0] num,
  input  logic signed [tcv_pkg::CoordW-1:0] den,
  output logic signed [tcv_pkg::CoordW-1:0] quo
);
  import tcv_pkg::*;

  localparam int NW = CoordW + FRAC_BITS;
  localparam int NST = (NW + DivStep - 1) / DivStep;
  localparam int QW = NST * DivStep;

  logic [QW-1:0]     rem_r [1:NST];
  logic [QW-1:0]     q_r   [1:NST];
  logic [CoordW-1:0] d_r   [1:NST];
  logic              neg_r [1:NST];
  logic              zero_r[1:NST];
  logic [1:0]        zs_r  [1:NST];

  logic [CoordW-1:0] nmag, dmag;
  assign nmag = num[CoordW-1] ? CoordW'(-num) : num;
  assign dmag = den[CoordW-1] ? CoordW'(-den) : den;

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [QW-1:0]     rem_in, q_in;
    logic [CoordW-1:0] d_in;
    logic              neg_in, zero_in;
    logic [1:0]        zs_in;
    logic [QW-1:0]     rem_nxt, q_nxt;

    if (s == 0) begin : g_head
      // The first stage starts from the operand magnitudes.
      assign rem_in  = '0;
      assign q_in    = QW'({nmag, FRAC_BITS'(0)});
      assign d_in    = dmag;
      assign neg_in  = num[CoordW-1] ^ den[CoordW-1];
      assign zero_in = (den == '0);
      assign zs_in   = {num[CoordW-1], num != '0};
    end else begin : g_body
      assign rem_in  = rem_r[s];
      assign q_in    = q_r[s];
      assign d_in    = d_r[s];
      assign neg_in  = neg_r[s];
      assign zero_in = zero_r[s];
      assign zs_in   = zs_r[s];
    end

    always_comb begin
      logic [QW:0] t;
      rem_nxt = rem_in;
      q_nxt   = q_in;
      for (int b = 0; b < DivStep; b++) begin
        t = {rem_nxt, q_nxt[QW-1]};
        q_nxt = {q_nxt[QW-2:0], 1'b0};
        if (t >= {{(QW+1-CoordW){1'b0}}, d_in}) begin
          rem_nxt = QW'(t - {{(QW+1-CoordW){1'b0}}, d_in});
          q_nxt[0] = 1'b1;
        end else begin
          rem_nxt = QW'(t);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1]  <= rem_nxt;
        q_r[s+1]    <= q_nxt;
        d_r[s+1]    <= d_in;
        neg_r[s+1]  <= neg_in;
        zero_r[s+1] <= zero_in;
        zs_r[s+1]   <= zs_in;
      end
    end
  end

  always_comb begin
    logic [QW-1:0] q;
    q = q_r[NST];
    if (zero_r[NST]) begin
      if (!zs_r[NST][0]) quo = '0;
      else if (zs_r[NST][1]) quo = {1'b1, {(CoordW-1){1'b0}}};
      else quo = {1'b0, {(CoordW-1){1'b1}}};
    end else if (neg_r[NST]) begin
      if (q > QW'({1'b1, {(CoordW-1){1'b0}}})) quo = {1'b1, {(CoordW-1){1'b0}}};
      else quo = CoordW'(-q);
    end else begin
      if (q > QW'({1'b0, {(CoordW-1){1'b1}}})) quo = {1'b0, {(CoordW-1){1'b1}}};
      else quo = CoordW'(q);
    end
  end
endmodule

// File: sv/tcv_back.sv
// Frustum and back-face test with viewport mapping, two register stages.
module tcv_back #(
  parameter int FRAC_BITS = tcv_pkg::FracBitsDefault
) (
  input  logic clk,
  input  logic adv,
  input  tcv_pkg::cfg_t cfg,
  input  logic signed [tcv_pkg::CoordW-1:0] ndc [tcv_pkg::NumDiv],
  output logic culled,
  output logic signed [tcv_pkg::CoordW-1:0] scr [tcv_pkg::NumDiv]
);
  import tcv_pkg::*;

  localparam logic signed [CoordW:0] One = (CoordW+1)'(1) <<< FRAC_BITS;

  // Stage A: outside tests, edges, screen products.
  logic signed [CoordW:0]        e_r [4];
  logic                          fc_r, en_r;
  logic signed [CoordW+SizeW+1:0] p_r [6];
  logic signed [CoordW-1:0]      z_r [3];
  // Stage B: cross products, clamped screen coordinates.
  logic signed [2*CoordW+1:0]    m_r [2];
  logic                          fc2_r, en2_r;
  logic signed [CoordW-1:0]      s_r [NumDiv];

  always_ff @(posedge clk) begin
    if (adv) begin
      logic o [3];
      for (int v = 0; v < 3; v++) begin
        o[v] = 1'b0;
        for (int k = 0; k < 3; k++)
          if ((CoordW+1)'(ndc[v*3+k]) < -One || (CoordW+1)'(ndc[v*3+k]) > One)
            o[v] = 1'b1;
        p_r[2*v]   <= ((CoordW+SizeW+2)'((CoordW+1)'(ndc[v*3]) + One)) *
                      $signed({1'b0, cfg.screen_width});
        p_r[2*v+1] <= ((CoordW+SizeW+2)'((CoordW+1)'(ndc[v*3+1]) + One)) *
                      $signed({1'b0, cfg.screen_height});
        z_r[v] <= ndc[v*3+2];
      end
      fc_r <= o[0] & o[1] & o[2];
      en_r <= cfg.back_cull_enable;
      e_r[0] <= (CoordW+1)'(ndc[3]) - (CoordW+1)'(ndc[0]);
      e_r[1] <= (CoordW+1)'(ndc[4]) - (CoordW+1)'(ndc[1]);
      e_r[2] <= (CoordW+1)'(ndc[6]) - (CoordW+1)'(ndc[3]);
      e_r[3] <= (CoordW+1)'(ndc[7]) - (CoordW+1)'(ndc[4]);
      m_r[0] <= e_r[0] * e_r[3];
      m_r[1] <= e_r[1] * e_r[2];
      fc2_r  <= fc_r;
      en2_r  <= en_r;
      for (int i = 0; i < 6; i++) begin
        logic signed [CoordW+SizeW+1:0] h;
        h = p_r[i] >>> 1;
        if (h > (CoordW+SizeW+2)'(32'sh7fffffff)) s_r[(i/2)*3 + i%2] <= 32'sh7fffffff;
        else if (h < -(CoordW+SizeW+2)'(33'sh80000000))
          s_r[(i/2)*3 + i%2] <= {1'b1, {(CoordW-1){1'b0}}};
        else s_r[(i/2)*3 + i%2] <= CoordW'(h);
      end
      for (int v = 0; v < 3; v++) s_r[v*3+2] <= z_r[v];
    end
  end

  always_comb begin
    culled = fc2_r | (en2_r & (m_r[0] < m_r[1]));
    for (int i = 0; i < NumDiv; i++) scr[i] = culled ? '0 : s_r[i];
  end
endmodule

// File: sv/triangle_cull_and_viewport_top.sv
// Top level of the triangle cull and viewport block.
// A triangle goes from input accept to output valid through the nine pipelined
// dividers and then the registered cull and viewport stages.
// Throughput: one triangle per cycle; the whole pipeline advances when the
// output register is empty or being taken.
// Reset: synchronous active-low; clears valid bits and loads register defaults.
module triangle_cull_and_viewport_top #(
  parameter int FRAC_BITS = tcv_pkg::FracBitsDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [tcv_pkg::SizeW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] in_a_x, in_a_y, in_a_z, in_a_w,
  input  logic signed [31:0] in_b_x, in_b_y, in_b_z, in_b_w,
  input  logic signed [31:0] in_c_x, in_c_y, in_c_z, in_c_w,
  output logic out_valid,
  input  logic out_ready,
  output logic out_culled,
  output logic signed [31:0] out_sa_x, out_sa_y, out_sa_z,
  output logic signed [31:0] out_sb_x, out_sb_y, out_sb_z,
  output logic signed [31:0] out_sc_x, out_sc_y, out_sc_z
);
  import tcv_pkg::*;

  localparam int NST = (CoordW + FRAC_BITS + DivStep - 1) / DivStep;
  localparam int LAT = NST + 2;

  cfg_t cfg_r;
  logic [LAT-1:0] vld_r;
  logic adv;

  // The pipeline moves as a whole whenever the last stage can be emptied.
  assign adv = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.back_cull_enable <= 1'b0;
      cfg_r.screen_width  <= SizeW'(640);
      cfg_r.screen_height <= SizeW'(480);
      vld_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_BACK_CULL: cfg_r.back_cull_enable <= cfg_data[0];
          CFG_WIDTH:     cfg_r.screen_width <= cfg_data;
          CFG_HEIGHT:    cfg_r.screen_height <= cfg_data;
          default: ;
        endcase
      end
      if (adv) vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  logic signed [CoordW-1:0] nums [NumDiv];
  logic signed [CoordW-1:0] dens [NumDiv];
  logic signed [CoordW-1:0] ndc  [NumDiv];
  logic signed [CoordW-1:0] scr  [NumDiv];

  assign nums = '{in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_c_x, in_c_y, in_c_z};
  assign dens = '{in_a_w, in_a_w, in_a_w, in_b_w, in_b_w, in_b_w, in_c_w, in_c_w, in_c_w};

  for (genvar i = 0; i < NumDiv; i++) begin : g_div
    tcv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .adv(adv), .num(nums[i]), .den(dens[i]), .quo(ndc[i])
    );
  end

  tcv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .adv(adv), .cfg(cfg_r), .ndc(ndc), .culled(out_culled), .scr(scr)
  );

  assign out_sa_x = scr[0];
  assign out_sa_y = scr[1];
  assign out_sa_z = scr[2];
  assign out_sb_x = scr[3];
  assign out_sb_y = scr[4];
  assign out_sb_z = scr[5];
  assign out_sc_x = scr[6];
  assign out_sc_y = scr[7];
  assign out_sc_z = scr[8];

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("output item dropped");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("stalled while empty");
  a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_culled |-> out_sa_x == 0 && out_sc_z == 0)
    else $error("culled item carries coordinates");
`endif
endmodule
